### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

### design/imm_pkg.sv
// ----------------------------------------------------------------------------
// imm_pkg
// Types, constants and helpers shared by the integer matrix multiply block.
// ----------------------------------------------------------------------------
package imm_pkg;

  localparam int MAX_DIM      = 16;
  localparam int ELEMENT_BITS = 16;
  localparam int WORD_W       = 32;
  localparam int CFG_W        = 5;
  localparam int DIM_W        = $clog2(MAX_DIM);
  localparam int ADDR_W       = 2 * DIM_W;
  localparam int DEPTH        = MAX_DIM * MAX_DIM;

  typedef enum logic [1:0] {
    CMD_LOAD_A   = 2'd0,
    CMD_LOAD_B   = 2'd1,
    CMD_MULTIPLY = 2'd2,
    CMD_READ     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_ROWS_A    = 2'd0,
    CFG_INNER_DIM = 2'd1,
    CFG_COLS_B    = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MULT,
    ST_DRAIN
  } state_e;

  // one MAC beat travelling down the pipeline
  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last;
    logic              zero;
    logic [ADDR_W-1:0] idx;
  } beat_t;

  // product store write
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } pwr_t;

  // register value 0 acts as 1, anything above MAX_DIM as MAX_DIM
  function automatic logic [DIM_W:0] eff_size(input logic [CFG_W-1:0] value);
    logic [DIM_W:0] res;
    if (value == '0) begin
      res = (DIM_W+1)'(1);
    end else if (32'(value) > MAX_DIM) begin
      res = (DIM_W+1)'(MAX_DIM);
    end else begin
      res = (DIM_W+1)'(value);
    end
    return res;
  endfunction

endpackage

### design/imm_mac.sv
// ----------------------------------------------------------------------------
// imm_mac
// Multiply and accumulate stages: registered product, then running sum that
// is written to the product store on the last beat of each element.
// ----------------------------------------------------------------------------
module imm_mac (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  imm_pkg::beat_t                       beat_i,
  input  logic [imm_pkg::ELEMENT_BITS-1:0]     a_i,
  input  logic [imm_pkg::ELEMENT_BITS-1:0]     b_i,
  output imm_pkg::pwr_t                        wr_o,
  output logic                                 busy_o
);

  localparam int EXT_W = imm_pkg::WORD_W - imm_pkg::ELEMENT_BITS;

  logic signed [imm_pkg::WORD_W-1:0] a_ext, b_ext, mul;
  imm_pkg::beat_t                    beat_q;
  logic [imm_pkg::WORD_W-1:0]        prod_q;
  logic [imm_pkg::WORD_W-1:0]        acc_q, acc_d;

  assign a_ext = {{EXT_W{a_i[imm_pkg::ELEMENT_BITS-1]}}, a_i};
  assign b_ext = {{EXT_W{b_i[imm_pkg::ELEMENT_BITS-1]}}, b_i};
  assign mul   = a_ext * b_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else begin
      beat_q <= beat_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= beat_i.zero ? '0 : mul;
    if (beat_q.valid) begin
      acc_q <= acc_d;
    end
  end

  assign acc_d = beat_q.first ? prod_q : acc_q + prod_q;

  assign wr_o.we   = beat_q.valid && beat_q.last;
  assign wr_o.addr = beat_q.idx;
  assign wr_o.data = acc_d;
  assign busy_o    = beat_q.valid;

endmodule

### design/integer_matrix_multiply.sv
// ----------------------------------------------------------------------------
// integer_matrix_multiply
// Integer matrix product over block memories for A, B and the product.
// ----------------------------------------------------------------------------
// Load beats are taken one per cycle while no multiply is running. A read
// beat waits until the previous read has reached the output register and
// that register is free or being emptied. A read answers through the product
// memory's registered port and then the output register. A multiply holds
// the input while one MAC pipeline walks all 256 product positions, one
// inner step per cycle for positions inside the configured size and a
// zeroing beat for each other position, fed by the single read port of each
// operand memory, and then while the pipeline drains. Reads before the first
// multiply return zero; no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module integer_matrix_multiply (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write port
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [imm_pkg::CFG_W-1:0]   cfg_data_i,
  // input stream
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [23:0]                 s_axis_tdata_i,  // row_index[3:0], col_index[7:4],
                                                       // element_value[23:8]
  input  logic [1:0]                  s_axis_tuser_i,  // command[1:0]
  // result stream
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [31:0]                 m_axis_tdata_o   // product_value[31:0]
);

  localparam int DIM_W  = imm_pkg::DIM_W;
  localparam int ADDR_W = imm_pkg::ADDR_W;
  localparam int EB     = imm_pkg::ELEMENT_BITS;
  localparam int WW     = imm_pkg::WORD_W;

  // configuration
  logic [imm_pkg::CFG_W-1:0] rows_a_q, inner_dim_q, cols_b_q;
  logic [DIM_W:0]            nr, nk, nc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= imm_pkg::CFG_W'(1);
      inner_dim_q <= imm_pkg::CFG_W'(1);
      cols_b_q    <= imm_pkg::CFG_W'(1);
    end else if (cfg_we_i) begin
      unique case (imm_pkg::cfg_idx_e'(cfg_index_i))
        imm_pkg::CFG_ROWS_A:    rows_a_q    <= cfg_data_i;
        imm_pkg::CFG_INNER_DIM: inner_dim_q <= cfg_data_i;
        imm_pkg::CFG_COLS_B:    cols_b_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign nr = imm_pkg::eff_size(rows_a_q);
  assign nk = imm_pkg::eff_size(inner_dim_q);
  assign nc = imm_pkg::eff_size(cols_b_q);

  // input decode
  imm_pkg::cmd_e     cmd;
  logic [3:0]        row_in, col_in;
  logic [15:0]       value_in;
  logic              in_bounds;
  logic [ADDR_W-1:0] in_addr;
  logic              s_fire;

  assign cmd       = imm_pkg::cmd_e'(s_axis_tuser_i);
  assign row_in    = s_axis_tdata_i[3:0];
  assign col_in    = s_axis_tdata_i[7:4];
  assign value_in  = s_axis_tdata_i[23:8];
  assign in_bounds = (32'(row_in) < imm_pkg::MAX_DIM) && (32'(col_in) < imm_pkg::MAX_DIM);
  assign in_addr   = {row_in[DIM_W-1:0], col_in[DIM_W-1:0]};
  assign s_fire    = s_axis_tvalid_i && s_axis_tready_o;

  // sequencer state
  imm_pkg::state_e state_q, state_d;
  logic [DIM_W-1:0] i_q, j_q, k_q, i_d, j_d, k_d;
  logic             mac_busy;
  imm_pkg::beat_t   beat_d, beat_q;
  logic             in_range, pos_last, final_beat;

  // read path
  logic          rd_pend_q, rd_zero_q, p_written_q;
  logic          m_valid_q;
  logic [WW-1:0] m_data_q;

  always_comb begin
    s_axis_tready_o = 1'b0;
    if (state_q == imm_pkg::ST_IDLE) begin
      if (cmd == imm_pkg::CMD_READ) begin
        s_axis_tready_o = !rd_pend_q && (!m_valid_q || m_axis_tready_i);
      end else begin
        s_axis_tready_o = 1'b1;
      end
    end
  end

  assign in_range   = ({1'b0, i_q} < nr) && ({1'b0, j_q} < nc);
  assign pos_last   = !in_range || ({1'b0, k_q} == nk - (DIM_W+1)'(1));
  assign final_beat = pos_last && (i_q == DIM_W'(imm_pkg::MAX_DIM - 1))
                      && (j_q == DIM_W'(imm_pkg::MAX_DIM - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      imm_pkg::ST_IDLE:  if (s_fire && cmd == imm_pkg::CMD_MULTIPLY) state_d = imm_pkg::ST_MULT;
      imm_pkg::ST_MULT:  if (final_beat) state_d = imm_pkg::ST_DRAIN;
      imm_pkg::ST_DRAIN: if (!beat_q.valid && !mac_busy) state_d = imm_pkg::ST_IDLE;
      default:           state_d = imm_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs and counters
  always_comb begin
    i_d    = i_q;
    j_d    = j_q;
    k_d    = k_q;
    beat_d = '0;
    unique case (state_q)
      imm_pkg::ST_IDLE: begin
        i_d = '0;
        j_d = '0;
        k_d = '0;
      end
      imm_pkg::ST_MULT: begin
        beat_d.valid = 1'b1;
        beat_d.first = !in_range || (k_q == '0);
        beat_d.last  = pos_last;
        beat_d.zero  = !in_range;
        beat_d.idx   = {i_q, j_q};
        if (pos_last) begin
          k_d = '0;
          if (j_q == DIM_W'(imm_pkg::MAX_DIM - 1)) begin
            j_d = '0;
            i_d = i_q + DIM_W'(1);
          end else begin
            j_d = j_q + DIM_W'(1);
          end
        end else begin
          k_d = k_q + DIM_W'(1);
        end
      end
      imm_pkg::ST_DRAIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= imm_pkg::ST_IDLE;
      beat_q  <= '0;
    end else begin
      state_q <= state_d;
      beat_q  <= beat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d;
    j_q <= j_d;
    k_q <= k_d;
  end

  // operand memories
  logic [EB-1:0] mem_a [imm_pkg::DEPTH];
  logic [EB-1:0] mem_b [imm_pkg::DEPTH];
  logic [EB-1:0] a_rd_q, b_rd_q;

  always_ff @(posedge clk_i) begin
    if (s_fire && in_bounds && cmd == imm_pkg::CMD_LOAD_A) begin
      mem_a[in_addr] <= value_in[EB-1:0];
    end
    a_rd_q <= mem_a[{i_q, k_q}];
  end

  always_ff @(posedge clk_i) begin
    if (s_fire && in_bounds && cmd == imm_pkg::CMD_LOAD_B) begin
      mem_b[in_addr] <= value_in[EB-1:0];
    end
    b_rd_q <= mem_b[{k_q, j_q}];
  end

  // MAC pipeline
  imm_pkg::pwr_t p_wr;

  imm_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (beat_q),
    .a_i    (a_rd_q),
    .b_i    (b_rd_q),
    .wr_o   (p_wr),
    .busy_o (mac_busy)
  );

  // product memory
  logic [WW-1:0] mem_p [imm_pkg::DEPTH];
  logic [WW-1:0] p_rd_q;
  logic          rd_fire;

  assign rd_fire = s_fire && cmd == imm_pkg::CMD_READ;

  always_ff @(posedge clk_i) begin
    if (p_wr.we) begin
      mem_p[p_wr.addr] <= p_wr.data;
    end
    if (rd_fire) begin
      p_rd_q <= mem_p[in_addr];
    end
  end

  // every multiply rewrites the whole store, so one flag covers reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_written_q <= 1'b0;
      rd_pend_q   <= 1'b0;
      rd_zero_q   <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      if (p_wr.we) begin
        p_written_q <= 1'b1;
      end
      rd_pend_q <= rd_fire;
      if (rd_fire) begin
        rd_zero_q <= !in_bounds || !p_written_q;
      end
      if (rd_pend_q) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_pend_q) begin
      m_data_q <= rd_zero_q ? '0 : p_rd_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  `ASSERT_CLK(a_accept_idle, s_fire |-> state_q == imm_pkg::ST_IDLE,
              "beat accepted while a multiply is running")
  `ASSERT_NEVER(a_pwr_idle, p_wr.we && state_q == imm_pkg::ST_IDLE,
                "product write seen with the sequencer idle")
  `ASSERT_CLK(a_out_free, rd_pend_q |-> !m_valid_q,
              "read data returned while the output register is still full")

endmodule
